FILE: hdl/assert_macros.svh
// assertion macros used by the drive sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also holds through reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: hdl/ebds_pkg.sv
// types and constants of the encoder balanced drive sequencer
`default_nettype none

package ebds_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int TICKS_W        = 16;
    localparam int INCH_W         = 5;
    localparam int PAUSE_W        = 24;
    localparam int CFG_DATA_W     = 24;
    localparam int CFG_INDEX_W    = 3;

    // target = floor(inches * ticks_milli / 1000), by reciprocal multiply
    localparam int PROD_W      = INCH_W + TICKS_W;
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 31;
    localparam int QUOT_FULL_W = PROD_W + RECIP_W;
    localparam int TARGET_W    = 11;
    localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'((64'd1 << RECIP_SHIFT) / 1000 + 1);

    localparam logic [TICKS_W-1:0] TPIM_RESET      = 16'd46314;
    localparam logic [TICKS_W-1:0] RIGHT_TURN_RESET = 16'd235;
    localparam logic [TICKS_W-1:0] LEFT_TURN_RESET  = 16'd230;
    localparam logic [PAUSE_W-1:0] PAUSE_RESET      = 24'd100000;

    // motor bits
    localparam logic [3:0] M_LEN  = 4'b0001;
    localparam logic [3:0] M_REN  = 4'b0010;
    localparam logic [3:0] M_LREV = 4'b0100;
    localparam logic [3:0] M_RREV = 4'b1000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_Y_INCHES   = 3'd0,
        REG_Y_NEGATIVE = 3'd1,
        REG_X_INCHES   = 3'd2,
        REG_X_NEGATIVE = 3'd3,
        REG_TPIM       = 3'd4,
        REG_RIGHT_TURN = 3'd5,
        REG_LEFT_TURN  = 3'd6,
        REG_PAUSE      = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LEG1  = 3'd1,
        PH_PAUSE = 3'd2,
        PH_PIVOT = 3'd3,
        PH_LEG2  = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    typedef struct packed {
        logic left_enc_level;
        logic right_enc_level;
        logic start_button;
    } poll_t;

    typedef struct packed {
        logic               left_enable;
        logic               right_enable;
        logic               left_reverse;
        logic               right_reverse;
        logic [2:0]         phase_now;
        logic [TICKS_W-1:0] left_ticks;
        logic [TICKS_W-1:0] right_ticks;
    } drive_t;

endpackage

`default_nettype wire

FILE: hdl/ebds_chan_if.sv
// valid/ready channel carrying one payload item per transfer
`default_nettype none

interface ebds_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

`default_nettype wire

FILE: hdl/encoder_balanced_drive_sequencer.sv
// two-leg drive sequencer with encoder edge counting and wheel balancing
// a polled item is held in the input register, then its result in the result register, before it is offered
// throughput: one poll per cycle while drive is not stalled, set by the single pass between the two registers
// leg targets follow a config write through the product register, then the target register
// reset: asynchronous active-low rst_n; idle phase, counts and pins cleared, motors off,
// config registers at their defaults
`default_nettype none
`include "assert_macros.svh"

module encoder_balanced_drive_sequencer
    import ebds_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    ebds_chan_if.sink                   poll,
    ebds_chan_if.source                 drive
);

    localparam int CMP_W = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;

    // configuration registers
    logic [INCH_W-1:0]  y_inches_reg, y_inches_next;
    logic               y_neg_reg, y_neg_next;
    logic [INCH_W-1:0]  x_inches_reg, x_inches_next;
    logic               x_neg_reg, x_neg_next;
    logic [TICKS_W-1:0] tpim_reg, tpim_next;
    logic [TICKS_W-1:0] right_turn_reg, right_turn_next;
    logic [TICKS_W-1:0] left_turn_reg, left_turn_next;
    logic [PAUSE_W-1:0] pause_items_reg, pause_items_next;

    // leg targets
    logic [PROD_W-1:0]      y_prod_reg, y_prod_next;
    logic [PROD_W-1:0]      x_prod_reg, x_prod_next;
    logic [QUOT_FULL_W-1:0] y_quot_full, x_quot_full;
    logic [TARGET_W-1:0]    y_target_reg, y_target_next;
    logic [TARGET_W-1:0]    x_target_reg, x_target_next;

    // handshake
    logic   s1_valid_reg, s1_valid_next;
    poll_t  s1_reg, s1_next;
    logic   out_valid_reg, out_valid_next;
    drive_t drive_reg, drive_next;
    logic   advance;
    logic   process;
    logic   poll_xfer;

    // sequencer state
    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] lc_reg, lc_next, lc_inc;
    logic [COUNT_BITS-1:0] rc_reg, rc_next, rc_inc;
    logic                  ll_reg, ll_next;
    logic                  rl_reg, rl_next;
    logic                  bl_reg, bl_next;
    logic [PAUSE_W-1:0]    pause_cnt_reg, pause_cnt_next;
    logic [3:0]            motor_reg, motor_next;

    // decisions
    logic              counting;
    logic              press;
    logic [CMP_W-1:0]  lc_cmp, rc_cmp, y_tgt_cmp, x_tgt_cmp, lim_cmp;
    logic [CMP_W-1:0]  lc_out, rc_out;
    logic [3:0]        bal_bits;
    logic [3:0]        pivot_dir;
    logic              leg1_end;
    logic              pause_done;
    logic              pivot_end;
    logic              leg2_end;

    // configuration writes
    always_comb
    begin
        y_inches_next    = y_inches_reg;
        y_neg_next       = y_neg_reg;
        x_inches_next    = x_inches_reg;
        x_neg_next       = x_neg_reg;
        tpim_next        = tpim_reg;
        right_turn_next  = right_turn_reg;
        left_turn_next   = left_turn_reg;
        pause_items_next = pause_items_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_Y_INCHES:   y_inches_next    = cfg_wdata[INCH_W-1:0];
                REG_Y_NEGATIVE: y_neg_next       = cfg_wdata[0];
                REG_X_INCHES:   x_inches_next    = cfg_wdata[INCH_W-1:0];
                REG_X_NEGATIVE: x_neg_next       = cfg_wdata[0];
                REG_TPIM:       tpim_next        = cfg_wdata[TICKS_W-1:0];
                REG_RIGHT_TURN: right_turn_next  = cfg_wdata[TICKS_W-1:0];
                REG_LEFT_TURN:  left_turn_next   = cfg_wdata[TICKS_W-1:0];
                REG_PAUSE:      pause_items_next = cfg_wdata[PAUSE_W-1:0];
                default:        y_inches_next    = y_inches_reg;
            endcase
        end
    end

    // targets from the values being written; the registered product is divided by 1000
    assign y_prod_next   = PROD_W'(y_inches_next) * PROD_W'(tpim_next);
    assign x_prod_next   = PROD_W'(x_inches_next) * PROD_W'(tpim_next);
    assign y_quot_full   = QUOT_FULL_W'(y_prod_reg) * QUOT_FULL_W'(RECIP_1000);
    assign x_quot_full   = QUOT_FULL_W'(x_prod_reg) * QUOT_FULL_W'(RECIP_1000);
    assign y_target_next = y_quot_full[RECIP_SHIFT +: TARGET_W];
    assign x_target_next = x_quot_full[RECIP_SHIFT +: TARGET_W];

    // transfer control
    assign advance    = !out_valid_reg || drive.ready;
    assign poll.ready = !s1_valid_reg || advance;
    assign poll_xfer  = poll.valid && poll.ready;
    assign process    = s1_valid_reg && advance;

    always_comb
    begin
        s1_next = poll_xfer ? poll.data : s1_reg;
        if (poll_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        if (process)
        begin
            out_valid_next = 1'b1;
        end
        else if (drive.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // edge counting and decisions
    assign counting = (phase_reg == PH_LEG1) || (phase_reg == PH_PIVOT)
                   || (phase_reg == PH_LEG2);
    assign press    = s1_reg.start_button && !bl_reg;

    assign lc_inc = (counting && s1_reg.left_enc_level && !ll_reg && (lc_reg != '1))
                  ? lc_reg + COUNT_BITS'(1) : lc_reg;
    assign rc_inc = (counting && s1_reg.right_enc_level && !rl_reg && (rc_reg != '1))
                  ? rc_reg + COUNT_BITS'(1) : rc_reg;

    assign lc_cmp    = CMP_W'(lc_inc);
    assign rc_cmp    = CMP_W'(rc_inc);
    assign y_tgt_cmp = CMP_W'(y_target_reg);
    assign x_tgt_cmp = CMP_W'(x_target_reg);
    assign lim_cmp   = x_neg_reg ? CMP_W'(left_turn_reg) : CMP_W'(right_turn_reg);

    assign bal_bits  = ((lc_cmp > rc_cmp) ? 4'b0000 : M_LEN)
                     | ((rc_cmp > lc_cmp) ? 4'b0000 : M_REN);
    assign pivot_dir = x_neg_reg ? M_LREV : M_RREV;

    assign leg1_end   = y_neg_reg ? ((lc_cmp >= y_tgt_cmp) || (rc_cmp >= y_tgt_cmp))
                                  : ((lc_cmp > y_tgt_cmp) && (rc_cmp > y_tgt_cmp));
    assign pause_done = !(pause_cnt_reg < pause_items_reg);
    assign pivot_end  = (lc_cmp >= lim_cmp) || (rc_cmp >= lim_cmp);
    assign leg2_end   = (lc_cmp > x_tgt_cmp) && (rc_cmp > x_tgt_cmp);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (process)
        begin
            case (phase_reg)
                PH_IDLE:  phase_next = press ? PH_LEG1 : PH_IDLE;
                PH_LEG1:  phase_next = leg1_end ? PH_PAUSE : PH_LEG1;
                PH_PAUSE: phase_next = pause_done ? PH_PIVOT : PH_PAUSE;
                PH_PIVOT: phase_next = pivot_end ? PH_LEG2 : PH_PIVOT;
                PH_LEG2:  phase_next = leg2_end ? PH_DONE : PH_LEG2;
                default:  phase_next = PH_DONE;
            endcase
        end
    end

    // counts, pause timer and motor bits
    always_comb
    begin
        ll_next        = ll_reg;
        rl_next        = rl_reg;
        bl_next        = bl_reg;
        lc_next        = lc_reg;
        rc_next        = rc_reg;
        pause_cnt_next = pause_cnt_reg;
        motor_next     = motor_reg;
        if (process)
        begin
            ll_next = s1_reg.left_enc_level;
            rl_next = s1_reg.right_enc_level;
            bl_next = s1_reg.start_button;
            lc_next = lc_inc;
            rc_next = rc_inc;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (press)
                    begin
                        lc_next = COUNT_BITS'(s1_reg.left_enc_level);
                        rc_next = COUNT_BITS'(s1_reg.right_enc_level);
                    end
                end
                PH_LEG1:
                begin
                    if (leg1_end)
                    begin
                        motor_next     = y_neg_reg ? (M_LREV | M_RREV) : 4'b0000;
                        pause_cnt_next = '0;
                    end
                    else
                    begin
                        motor_next = bal_bits | (y_neg_reg ? (M_LREV | M_RREV) : 4'b0000);
                    end
                end
                PH_PAUSE:
                begin
                    if (pause_done)
                    begin
                        motor_next = pivot_dir;
                        lc_next    = COUNT_BITS'(s1_reg.left_enc_level);
                        rc_next    = COUNT_BITS'(s1_reg.right_enc_level);
                    end
                    else
                    begin
                        pause_cnt_next = pause_cnt_reg + PAUSE_W'(1);
                    end
                end
                PH_PIVOT:
                begin
                    if (pivot_end)
                    begin
                        motor_next = pivot_dir;
                        lc_next    = COUNT_BITS'(s1_reg.left_enc_level);
                        rc_next    = COUNT_BITS'(s1_reg.right_enc_level);
                    end
                    else
                    begin
                        motor_next = bal_bits | pivot_dir;
                    end
                end
                PH_LEG2:
                begin
                    motor_next = leg2_end ? 4'b0000 : bal_bits;
                end
                default:
                begin
                    motor_next = motor_reg & (M_LREV | M_RREV);
                end
            endcase
        end
    end

    // result item
    assign lc_out = CMP_W'(lc_next);
    assign rc_out = CMP_W'(rc_next);

    always_comb
    begin
        drive_next = drive_reg;
        if (process)
        begin
            drive_next.left_enable   = motor_next[0];
            drive_next.right_enable  = motor_next[1];
            drive_next.left_reverse  = motor_next[2];
            drive_next.right_reverse = motor_next[3];
            drive_next.phase_now     = phase_next;
            drive_next.left_ticks    = lc_out[TICKS_W-1:0];
            drive_next.right_ticks   = rc_out[TICKS_W-1:0];
        end
    end

    assign drive.valid = out_valid_reg;
    assign drive.data  = drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_inches_reg    <= '0;
            y_neg_reg       <= 1'b0;
            x_inches_reg    <= '0;
            x_neg_reg       <= 1'b0;
            tpim_reg        <= TPIM_RESET;
            right_turn_reg  <= RIGHT_TURN_RESET;
            left_turn_reg   <= LEFT_TURN_RESET;
            pause_items_reg <= PAUSE_RESET;
            y_prod_reg      <= '0;
            x_prod_reg      <= '0;
            y_target_reg    <= '0;
            x_target_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_IDLE;
            lc_reg          <= '0;
            rc_reg          <= '0;
            ll_reg          <= 1'b0;
            rl_reg          <= 1'b0;
            bl_reg          <= 1'b0;
            pause_cnt_reg   <= '0;
            motor_reg       <= '0;
        end
        else
        begin
            y_inches_reg    <= y_inches_next;
            y_neg_reg       <= y_neg_next;
            x_inches_reg    <= x_inches_next;
            x_neg_reg       <= x_neg_next;
            tpim_reg        <= tpim_next;
            right_turn_reg  <= right_turn_next;
            left_turn_reg   <= left_turn_next;
            pause_items_reg <= pause_items_next;
            y_prod_reg      <= y_prod_next;
            x_prod_reg      <= x_prod_next;
            y_target_reg    <= y_target_next;
            x_target_reg    <= x_target_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            phase_reg       <= phase_next;
            lc_reg          <= lc_next;
            rc_reg          <= rc_next;
            ll_reg          <= ll_next;
            rl_reg          <= rl_next;
            bl_reg          <= bl_next;
            pause_cnt_reg   <= pause_cnt_next;
            motor_reg       <= motor_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_reg    <= s1_next;
        drive_reg <= drive_next;
    end

    `ASSERT_CLK(a_done_holds, clk, rst_n,
        (phase_reg == PH_DONE) |=> (phase_reg == PH_DONE), "done phase left")

    `ASSERT_CLK_ALWAYS(a_done_motors_off, clk,
        (phase_reg == PH_DONE) |-> (motor_reg[1:0] == 2'b00), "motor enabled in done phase")

    `ASSERT_CLK(a_pause_counts_still, clk, rst_n,
        (process && (phase_reg == PH_PAUSE) && !pause_done)
            |=> ($stable(lc_reg) && $stable(rc_reg)),
        "counts moved during pause")

    `ASSERT_CLK(a_result_from_item, clk, rst_n,
        $rose(out_valid_reg) |-> $past(s1_valid_reg), "result offered without a held poll")

endmodule

`default_nettype wire

FILE: sim/ebds_drive_checker.sv
// checker: follows the poll and drive channels, predicts each drive result and compares it
module ebds_drive_checker
    import ebds_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    ebds_chan_if                        poll_bus,
    ebds_chan_if                        drive_bus,
    output int                          mismatches,
    output int                          outstanding,
    output int                          checked
);

    localparam int unsigned MILLI_PER_TICK = 1000;
    localparam logic [COUNT_BITS_DEF-1:0] COUNT_TOP = '1;

    logic [INCH_W-1:0]         y_len;
    logic [INCH_W-1:0]         x_len;
    logic                      y_back;
    logic                      x_left;
    logic [TICKS_W-1:0]        milli_ticks;
    logic [TICKS_W-1:0]        right_pivot_len;
    logic [TICKS_W-1:0]        left_pivot_len;
    logic [PAUSE_W-1:0]        pause_len;

    phase_t                    phase;
    logic [COUNT_BITS_DEF-1:0] left_cnt;
    logic [COUNT_BITS_DEF-1:0] right_cnt;
    logic                      left_prev;
    logic                      right_prev;
    logic                      button_prev;
    logic [PAUSE_W-1:0]        pause_cnt;
    logic [3:0]                motors;

    drive_t                    expected_drives[$];

    function automatic logic [TICKS_W-1:0] leg_distance(input logic [INCH_W-1:0] inches);
        int unsigned prod;
        prod = 32'(inches) * 32'(milli_ticks);
        return TICKS_W'(prod / MILLI_PER_TICK);
    endfunction

    function automatic logic [3:0] even_drive();
        logic [3:0] bits;
        bits = '0;
        if (!(left_cnt > right_cnt))
            bits = bits | M_LEN;
        if (!(right_cnt > left_cnt))
            bits = bits | M_REN;
        return bits;
    endfunction

    function automatic logic [3:0] pivot_side();
        return x_left ? M_LREV : M_RREV;
    endfunction

    task automatic advance(input poll_t p, output drive_t d);
        logic               press;
        logic [TICKS_W-1:0] target;
        logic [TICKS_W-1:0] turn_len;
        press = p.start_button && !button_prev;
        if (phase inside {PH_LEG1, PH_PIVOT, PH_LEG2})
        begin
            if (p.left_enc_level && !left_prev && left_cnt != COUNT_TOP)
                left_cnt = left_cnt + COUNT_BITS_DEF'(1);
            if (p.right_enc_level && !right_prev && right_cnt != COUNT_TOP)
                right_cnt = right_cnt + COUNT_BITS_DEF'(1);
        end
        left_prev = p.left_enc_level;
        right_prev = p.right_enc_level;
        button_prev = p.start_button;

        case (phase)
            PH_IDLE:
            begin
                if (press)
                begin
                    left_cnt = COUNT_BITS_DEF'(p.left_enc_level);
                    right_cnt = COUNT_BITS_DEF'(p.right_enc_level);
                    phase = PH_LEG1;
                end
            end
            PH_LEG1:
            begin
                target = leg_distance(y_len);
                if (y_back)
                begin
                    if (left_cnt >= target || right_cnt >= target)
                    begin
                        motors = M_LREV | M_RREV;
                        phase = PH_PAUSE;
                        pause_cnt = '0;
                    end
                    else
                        motors = even_drive() | M_LREV | M_RREV;
                end
                else if (left_cnt <= target || right_cnt <= target)
                    motors = even_drive();
                else
                begin
                    motors = '0;
                    phase = PH_PAUSE;
                    pause_cnt = '0;
                end
            end
            PH_PAUSE:
            begin
                if (pause_cnt < pause_len)
                    pause_cnt = pause_cnt + PAUSE_W'(1);
                else
                begin
                    motors = pivot_side();
                    left_cnt = COUNT_BITS_DEF'(p.left_enc_level);
                    right_cnt = COUNT_BITS_DEF'(p.right_enc_level);
                    phase = PH_PIVOT;
                end
            end
            PH_PIVOT:
            begin
                turn_len = x_left ? left_pivot_len : right_pivot_len;
                if (left_cnt >= turn_len || right_cnt >= turn_len)
                begin
                    motors = pivot_side();
                    left_cnt = COUNT_BITS_DEF'(p.left_enc_level);
                    right_cnt = COUNT_BITS_DEF'(p.right_enc_level);
                    phase = PH_LEG2;
                end
                else
                    motors = even_drive() | pivot_side();
            end
            PH_LEG2:
            begin
                target = leg_distance(x_len);
                if (left_cnt <= target || right_cnt <= target)
                    motors = even_drive();
                else
                begin
                    motors = '0;
                    phase = PH_DONE;
                end
            end
            default:
            begin
                motors = motors & (M_LREV | M_RREV);
                phase = PH_DONE;
            end
        endcase

        d.left_enable = |(motors & M_LEN);
        d.right_enable = |(motors & M_REN);
        d.left_reverse = |(motors & M_LREV);
        d.right_reverse = |(motors & M_RREV);
        d.phase_now = phase;
        d.left_ticks = TICKS_W'(left_cnt);
        d.right_ticks = TICKS_W'(right_cnt);
    endtask

    task automatic check_field(input string field, input logic [TICKS_W-1:0] want,
                               input logic [TICKS_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("drive mismatch on %s: expected %0d, got %0d", field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : watch
        drive_t want;
        drive_t fresh;
        if (!rst_n)
        begin
            y_len = '0;
            x_len = '0;
            y_back = 1'b0;
            x_left = 1'b0;
            milli_ticks = TPIM_RESET;
            right_pivot_len = RIGHT_TURN_RESET;
            left_pivot_len = LEFT_TURN_RESET;
            pause_len = PAUSE_RESET;
            phase = PH_IDLE;
            left_cnt = '0;
            right_cnt = '0;
            left_prev = 1'b0;
            right_prev = 1'b0;
            button_prev = 1'b0;
            pause_cnt = '0;
            motors = '0;
            expected_drives.delete();
            mismatches = 0;
            checked = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_Y_INCHES:   y_len = cfg_wdata[INCH_W-1:0];
                    REG_Y_NEGATIVE: y_back = cfg_wdata[0];
                    REG_X_INCHES:   x_len = cfg_wdata[INCH_W-1:0];
                    REG_X_NEGATIVE: x_left = cfg_wdata[0];
                    REG_TPIM:       milli_ticks = cfg_wdata[TICKS_W-1:0];
                    REG_RIGHT_TURN: right_pivot_len = cfg_wdata[TICKS_W-1:0];
                    REG_LEFT_TURN:  left_pivot_len = cfg_wdata[TICKS_W-1:0];
                    default:        pause_len = cfg_wdata[PAUSE_W-1:0];
                endcase
            end

            if (drive_bus.valid && drive_bus.ready)
            begin
                if (expected_drives.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("drive transfer with no prediction pending");
                end
                else
                begin
                    want = expected_drives.pop_front();
                    checked++;
                    check_field("left_enable", TICKS_W'(want.left_enable),
                                TICKS_W'(drive_bus.data.left_enable));
                    check_field("right_enable", TICKS_W'(want.right_enable),
                                TICKS_W'(drive_bus.data.right_enable));
                    check_field("left_reverse", TICKS_W'(want.left_reverse),
                                TICKS_W'(drive_bus.data.left_reverse));
                    check_field("right_reverse", TICKS_W'(want.right_reverse),
                                TICKS_W'(drive_bus.data.right_reverse));
                    check_field("phase_now", TICKS_W'(want.phase_now),
                                TICKS_W'(drive_bus.data.phase_now));
                    check_field("left_ticks", want.left_ticks, drive_bus.data.left_ticks);
                    check_field("right_ticks", want.right_ticks, drive_bus.data.right_ticks);
                end
            end

            if (poll_bus.valid && poll_bus.ready)
            begin
                advance(poll_bus.data, fresh);
                expected_drives.push_back(fresh);
            end
            outstanding = expected_drives.size();
        end
    end

endmodule

FILE: sim/tb.sv
// testbench top: clock, reset, poll stimulus, register writes and verdict
module tb;
    import ebds_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LEAD_EDGES  = 12;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    bit gaps_on;
    int cycles = 0;
    int polls_sent = 0;
    int mismatches;
    int outstanding;
    int checked;

    ebds_chan_if #(.payload_t(poll_t))  poll_ch ();
    ebds_chan_if #(.payload_t(drive_t)) drive_ch ();

    encoder_balanced_drive_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .poll      (poll_ch),
        .drive     (drive_ch)
    );

    ebds_drive_checker drive_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .poll_bus    (poll_ch),
        .drive_bus   (drive_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        drive_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                drive_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            drive_ch.ready <= 1'b1;
        end
    end

    task automatic send_poll(input logic l, input logic r, input logic b);
        poll_t item;
        item.left_enc_level = l;
        item.right_enc_level = r;
        item.start_button = b;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            poll_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        poll_ch.valid <= 1'b1;
        poll_ch.data <= item;
        do
            @(posedge clk);
        while (poll_ch.ready !== 1'b1);
        polls_sent++;
    endtask

    task automatic random_polls(input int n, input bit gaps);
        gaps_on = gaps;
        repeat (n)
            send_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 3) == 0);
    endtask

    // stop polling and wait until every drive result is back
    task automatic quiesce();
        poll_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // deassert the write enable and wait for the leg targets to follow the last write
    task automatic settle();
        cfg_wr_en <= 1'b0;
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_Y_INCHES;
        cfg_wdata <= '0;
        poll_ch.valid <= 1'b0;
        poll_ch.data <= '0;
        gaps_on = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_Y_INCHES, 24'd31);
        write_reg(REG_Y_NEGATIVE, 24'd1);
        write_reg(REG_X_INCHES, 24'd31);
        write_reg(REG_X_NEGATIVE, 24'd0);
        write_reg(REG_TPIM, 24'd65535);
        write_reg(REG_RIGHT_TURN, 24'd65535);
        write_reg(REG_LEFT_TURN, 24'd65535);
        write_reg(REG_PAUSE, 24'hFFFFFF);
        settle();

        // idle pin activity, then press with the left pin high
        send_poll(1'b1, 1'b1, 1'b0);
        send_poll(1'b0, 1'b0, 1'b0);
        send_poll(1'b1, 1'b0, 1'b0);
        send_poll(1'b0, 1'b1, 1'b0);
        send_poll(1'b1, 1'b0, 1'b1);
        // reverse leg, button held and pressed again
        send_poll(1'b1, 1'b0, 1'b1);
        send_poll(1'b0, 1'b1, 1'b0);
        send_poll(1'b1, 1'b1, 1'b1);
        send_poll(1'b0, 1'b0, 1'b0);
        send_poll(1'b1, 1'b1, 1'b0);
        random_polls(200, 1'b1);

        quiesce();
        write_reg(REG_Y_NEGATIVE, 24'd0);
        settle();
        random_polls(200, 1'b1);

        // left wheel runs ahead while the right wheel stays still
        gaps_on = 1'b0;
        repeat (LEAD_EDGES)
        begin
            send_poll(1'b0, 1'b0, 1'b0);
            send_poll(1'b1, 1'b0, 1'b0);
        end
        send_poll(1'b1, 1'b1, 1'b0);

        // back to a reverse leg
        quiesce();
        write_reg(REG_Y_NEGATIVE, 24'd1);
        settle();
        send_poll(1'b0, 1'b0, 1'b0);
        random_polls(150, 1'b1);

        quiesce();
        write_reg(REG_PAUSE, 24'd0);
        settle();
        send_poll(1'b1, 1'b0, 1'b0);
        random_polls(120, 1'b1);

        quiesce();
        write_reg(REG_X_NEGATIVE, 24'd1);
        settle();
        random_polls(120, 1'b0);

        quiesce();
        write_reg(REG_LEFT_TURN, 24'd0);
        settle();
        send_poll(1'b0, 1'b1, 1'b0);
        random_polls(150, 1'b1);
        random_polls(150, 1'b0);

        quiesce();
        write_reg(REG_TPIM, 24'd0);
        write_reg(REG_X_INCHES, 24'd0);
        write_reg(REG_Y_INCHES, 24'd0);
        write_reg(REG_RIGHT_TURN, 24'd0);
        settle();
        random_polls(60, 1'b0);

        quiesce();
        repeat (8) @(posedge clk);
        $display("%0d polls driven, %0d drive results compared", polls_sent, checked);
        $display("run went idle to done: reverse and forward legs, pause, pivot, one wheel ahead");
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
